>>> rtl/sst_pkg.sv
package sst_pkg;

   // Fixed field widths of the request and response words.
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int KEY_W       = 64;
   localparam int OWNER_W     = 32;
   localparam int IDX_W       = 4;
   localparam int CNT_OUT_W   = 5;
   localparam int LIMIT_W     = 5;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - IDX_W - 2 * CNT_OUT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Request kinds carried on req_tuser.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE       = 2'd0,
      ACT_VALIDATE     = 2'd1,
      ACT_REMOVE       = 2'd2,
      ACT_REMOVE_OWNER = 2'd3
   } action_type;

   // Response codes carried on rsp_tuser.
   typedef enum logic [STATUS_W-1:0] {
      RSP_OK        = 2'd0,
      RSP_FULL      = 2'd1,
      RSP_NOT_FOUND = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_APPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic match;
      logic apply;
   } cmd_type;

endpackage

>>> rtl/sst_ctrl.sv
module sst_ctrl
   import sst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new word when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_MATCH: begin
            cmd.match = 1'b1;
         end
         S_APPLY: begin
            cmd.apply = out_free;
         end
         default: ;
      endcase
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A new response word appears only out of the apply step.
   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("response raised outside apply step");

   // An accepted request is always followed by the match step.
   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MATCH))
      else $error("accepted request did not enter match step");

   // A result never overwrites a word that is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid_ff || rsp_tready))
      else $error("apply while response word is stalled");

endmodule

>>> rtl/sst_datapath.sv
module sst_datapath
   import sst_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 64,
   parameter int OWNER_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [ACTION_W-1:0]   req_tuser,
   input  logic                  csr_valid,
   input  logic [LIMIT_W-1:0]    csr_data,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int SIDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int CMP_W    = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
   localparam int OWN_TAKE = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;

   // Slot storage and table state.
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_mem_ff [SLOTS];
   logic [OWNER_BITS-1:0] own_mem_ff [SLOTS];
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LIMIT_W-1:0]    limit_ff;

   // Request capture.
   action_type            act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [OWNER_BITS-1:0] own_ff;

   // Match results.
   logic [SLOTS-1:0] key_hit_ff, key_hit_in;
   logic [SLOTS-1:0] own_hit_ff, own_hit_in;
   logic [SLOTS-1:0] free_ff, free_in;
   logic             room_ff, room_in;
   logic [CMP_W-1:0] lim_eff;

   // Apply step.
   logic [SIDX_W-1:0] free_idx, key_idx, own_idx, res_idx;
   logic [CNT_W-1:0]  own_cnt, res_freed;
   status_type        res_status;
   logic              wr_en;

   // Response register.
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type            rsp_status_ff;

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action_type'(req_tuser);
         key_ff <= req_tdata[KEY_BITS-1:0];
         own_ff <= OWNER_BITS'(req_tdata[KEY_W +: OWN_TAKE]);
      end
   end

   // Limit register; a limit above the table size acts as the table size.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   assign lim_eff = (CMP_W'(limit_ff) > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : CMP_W'(limit_ff);

   // Compare every slot below the limit against the request in parallel.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         key_hit_in[i] = valid_ff[i] && (CMP_W'(i) < lim_eff) && (key_mem_ff[i] == key_ff);
         own_hit_in[i] = valid_ff[i] && (CMP_W'(i) < lim_eff) && (own_mem_ff[i] == own_ff);
         free_in[i]    = !valid_ff[i] && (CMP_W'(i) < lim_eff);
      end
      room_in = CMP_W'(count_ff) < lim_eff;
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         key_hit_ff <= key_hit_in;
         own_hit_ff <= own_hit_in;
         free_ff    <= free_in;
         room_ff    <= room_in;
      end
   end

   // Lowest set bit of each match vector, and the owner match count.
   always_comb begin
      free_idx = '0;
      key_idx  = '0;
      own_idx  = '0;
      own_cnt  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_ff[i])    free_idx = SIDX_W'(i);
         if (key_hit_ff[i]) key_idx  = SIDX_W'(i);
         if (own_hit_ff[i]) own_idx  = SIDX_W'(i);
      end
      for (int i = 0; i < SLOTS; i++) begin
         own_cnt = own_cnt + CNT_W'(own_hit_ff[i]);
      end
   end

   // Work out the table update and the response for the request.
   always_comb begin
      valid_in   = valid_ff;
      count_in   = count_ff;
      res_status = RSP_OK;
      res_idx    = '0;
      res_freed  = '0;
      wr_en      = 1'b0;
      case (act_ff)
         ACT_CREATE: begin
            if (room_ff && (|free_ff)) begin
               valid_in[free_idx] = 1'b1;
               wr_en              = 1'b1;
               res_idx            = free_idx;
               count_in           = count_ff + CNT_W'(1);
            end else begin
               res_status = RSP_FULL;
            end
         end
         ACT_VALIDATE: begin
            if (|key_hit_ff) begin
               res_idx = key_idx;
            end else begin
               res_status = RSP_NOT_FOUND;
            end
         end
         ACT_REMOVE: begin
            if (|key_hit_ff) begin
               valid_in[key_idx] = 1'b0;
               res_idx           = key_idx;
               res_freed         = CNT_W'(1);
               count_in          = (count_ff == '0) ? '0 : count_ff - CNT_W'(1);
            end else begin
               res_status = RSP_NOT_FOUND;
            end
         end
         ACT_REMOVE_OWNER: begin
            valid_in  = valid_ff & ~own_hit_ff;
            res_idx   = own_idx;
            res_freed = own_cnt;
            count_in  = (count_ff >= own_cnt) ? count_ff - own_cnt : '0;
         end
         default: ;
      endcase
   end

   // Table state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.apply) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // Key and owner are written into the allocated slot.
   always_ff @(posedge clock) begin
      if (cmd.apply && wr_en) begin
         key_mem_ff[free_idx] <= key_ff;
         own_mem_ff[free_idx] <= own_ff;
      end
   end

   // Response word: index, freed count and live count, status on the side.
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_data_ff   <= {RSP_PAD_W'(0), CNT_OUT_W'(count_in), CNT_OUT_W'(res_freed),
                           IDX_W'(res_idx)};
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

   // The live count tracks the number of valid slots.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("live count differs from valid slots");

   // The live count never goes past the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= SLOTS)
      else $error("live count above table size");

   // A captured match never marks a slot both free and holding the key.
   a_hit_free_excl: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.match) |-> ((key_hit_ff & free_ff) == '0))
      else $error("slot both free and matched");

endmodule

>>> rtl/session_slot_table_top.sv
// Session slot table.
// Requests enter on the req_ channel: req_tuser carries the action (create,
// validate, remove by key, remove all of an owner), req_tdata the session key
// and owner id. Every request yields exactly one word on the rsp_ channel:
// rsp_tuser carries the status, rsp_tdata the slot index, freed count and
// live count after the request.
// The csr_ channel writes the slot limit; it is always ready. The user must
// write it only while no request is in flight; the block itself does not enforce this.
// A request passes through capture, a parallel compare of all slots into
// registered hit vectors, and a priority-encoded update of the table together
// with the response load into the output register.
// One request is in flight at a time: a new request is not accepted until
// the update of the previous one has been made.
// The response sits in an output register; while the receiver stalls, the
// next request is still accepted and compared, and its update waits until
// the held word is taken.
// Reset (synchronous) empties the table, clears the live count and sets the
// slot limit to sixteen; no clearing pass is needed.
module session_slot_table_top
   import sst_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int KEY_BITS   = 64,
   parameter int OWNER_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // session_key[63:0], owner_id[95:64]
   input  logic [ACTION_W-1:0]   req_tuser,   // action[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slot_index[3:0], freed_count[8:4],
                                              // live_count[13:9], zero[15:14]
   output logic [STATUS_W-1:0]   rsp_tuser,   // status[1:0]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_W-1:0]    csr_data
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sst_datapath #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> sim/tb_top.sv
module tb_top;
   import sst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT  = 16;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 166;
   localparam int HOLD_CYCLES = 80;

   // One expected response word, split into its fields.
   typedef struct packed {
      status_type           status;
      logic [IDX_W-1:0]     slot;
      logic [CNT_OUT_W-1:0] freed;
      logic [CNT_OUT_W-1:0] live;
   } table_result;

   // Shadow copy of the slot table and the queue of responses it predicts.
   class session_table_scoreboard;
      bit                   slot_valid[SLOT_COUNT];
      logic [KEY_W-1:0]     slot_key[SLOT_COUNT];
      logic [OWNER_W-1:0]   slot_owner[SLOT_COUNT];
      int                   live_count;
      logic [LIMIT_W-1:0]   slot_limit;
      table_result          awaited[$];
      int                   mismatches;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_owner[i] = '0;
         end
         live_count = 0;
         slot_limit = LIMIT_RESET;
         mismatches = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         slot_limit = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Apply one accepted request to the shadow table and queue its response.
      function void note_request(action_type act, logic [KEY_W-1:0] key,
                                 logic [OWNER_W-1:0] owner);
         table_result r;
         int          lim;
         bit          hit;
         lim      = (slot_limit > SLOT_COUNT) ? SLOT_COUNT : int'(slot_limit);
         r.status = RSP_OK;
         r.slot   = '0;
         r.freed  = '0;
         hit      = 1'b0;
         case (act)
            ACT_CREATE: begin
               if (live_count >= lim) begin
                  r.status = RSP_FULL;
               end else begin
                  for (int i = 0; i < lim; i++) begin
                     if (!hit && !slot_valid[i]) begin
                        hit    = 1'b1;
                        r.slot = i[IDX_W-1:0];
                     end
                  end
                  if (hit) begin
                     slot_valid[r.slot] = 1'b1;
                     slot_key[r.slot]   = key;
                     slot_owner[r.slot] = owner;
                     live_count++;
                  end else begin
                     r.status = RSP_FULL;
                  end
               end
            end
            ACT_VALIDATE, ACT_REMOVE: begin
               for (int i = 0; i < lim; i++) begin
                  if (!hit && slot_valid[i] && slot_key[i] == key) begin
                     hit    = 1'b1;
                     r.slot = i[IDX_W-1:0];
                  end
               end
               if (!hit) begin
                  r.status = RSP_NOT_FOUND;
               end else if (act == ACT_REMOVE) begin
                  slot_valid[r.slot] = 1'b0;
                  r.freed = 1;
                  if (live_count > 0) live_count--;
               end
            end
            default: begin
               // Remove every searched slot of this owner; report the lowest one.
               for (int i = 0; i < lim; i++) begin
                  if (slot_valid[i] && slot_owner[i] == owner) begin
                     if (!hit) begin
                        hit    = 1'b1;
                        r.slot = i[IDX_W-1:0];
                     end
                     slot_valid[i] = 1'b0;
                     r.freed++;
                     if (live_count > 0) live_count--;
                  end
               end
            end
         endcase
         r.live = live_count[CNT_OUT_W-1:0];
         awaited.push_back(r);
      endfunction

      // Compare one accepted response word with the oldest expectation.
      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [RSP_DATA_W-1:0] data);
         table_result exp_r;
         bit          bad;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with none expected: status=%0d data=%h",
                        status, data);
            return;
         end
         exp_r = awaited.pop_front();
         bad = (status != exp_r.status)
            || (data[IDX_W-1:0] != exp_r.slot)
            || (data[IDX_W +: CNT_OUT_W] != exp_r.freed)
            || (data[IDX_W+CNT_OUT_W +: CNT_OUT_W] != exp_r.live)
            || (data[RSP_DATA_W-1 -: RSP_PAD_W] != '0);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response mismatch: expected status=%0d slot=%0d ",
                         "freed=%0d live=%0d, got status=%0d slot=%0d freed=%0d ",
                         "live=%0d pad=%0d"},
                        exp_r.status, exp_r.slot, exp_r.freed, exp_r.live,
                        status, data[IDX_W-1:0], data[IDX_W +: CNT_OUT_W],
                        data[IDX_W+CNT_OUT_W +: CNT_OUT_W],
                        data[RSP_DATA_W-1 -: RSP_PAD_W]);
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ACTION_W-1:0]   req_tuser  = ACT_CREATE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data   = '0;

   // No random idling on either side while this is set.
   bit calm         = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done    = 1'b0;
   int hold_left    = 0;

   logic [KEY_W-1:0]   key_pool[8];
   logic [OWNER_W-1:0] owner_pool[4];

   session_table_scoreboard sessions = new();

   session_slot_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 21);
      end
   end

   // Every response word taken by the receiver is checked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sessions.check_response(rsp_tuser, rsp_tdata);
   end

   // Offer one request word, called at a falling edge; returns at a falling edge.
   task automatic send_request(input action_type act, input logic [KEY_W-1:0] key,
                               input logic [OWNER_W-1:0] owner);
      while (!calm && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {owner, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sessions.note_request(act, key, owner);
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected response has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sessions.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sessions.set_limit(value);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 85) return key_pool[3'($urandom_range(7))];
      return {$urandom, $urandom};
   endfunction

   function automatic logic [OWNER_W-1:0] pick_owner();
      if ($urandom_range(99) < 85) return owner_pool[2'($urandom_range(3))];
      return $urandom;
   endfunction

   // Stimulus: directed cases first, then random phases under varied limits.
   initial begin
      logic [LIMIT_W-1:0] phase_limit[PHASES];
      int                 pick;
      action_type         act;
      phase_limit = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd0, 5'd16, 5'd0};
      phase_limit[5] = LIMIT_W'($urandom_range(31));
      phase_limit[7] = LIMIT_W'($urandom_range(16, 1));
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) owner_pool[i] = $urandom;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset limit: fill a few slots, duplicates included, then hit and miss.
      send_request(ACT_CREATE, '0, '0);
      send_request(ACT_CREATE, '1, '1);
      send_request(ACT_CREATE, {32{2'b01}}, {16{2'b10}});
      send_request(ACT_CREATE, '0, 32'd7);
      send_request(ACT_VALIDATE, '0, '0);
      send_request(ACT_VALIDATE, '1, '0);
      send_request(ACT_VALIDATE, 64'd123, '0);
      send_request(ACT_REMOVE, '0, '0);
      send_request(ACT_VALIDATE, '0, '1);
      send_request(ACT_CREATE, 64'd9, '1);
      send_request(ACT_REMOVE, 64'hdead, '0);
      send_request(ACT_REMOVE_OWNER, '0, '1);
      send_request(ACT_REMOVE_OWNER, '1, 32'h1234);
      wait_idle();

      // Limit equal to the live count: create is refused, upper slots are hidden.
      write_limit(5'd2);
      send_request(ACT_CREATE, 64'd1, 32'd1);
      send_request(ACT_VALIDATE, '0, '0);
      wait_idle();

      // Limit of zero searches nothing.
      write_limit(5'd0);
      send_request(ACT_CREATE, 64'd1, 32'd1);
      send_request(ACT_VALIDATE, {32{2'b01}}, '0);
      send_request(ACT_REMOVE_OWNER, '0, 32'd7);
      wait_idle();

      // Limit beyond the table acts as the full table.
      write_limit(5'd31);
      send_request(ACT_VALIDATE, '0, '0);
      wait_idle();

      // Small limit filled up to refusal.
      write_limit(5'd4);
      send_request(ACT_CREATE, 64'd1, 32'd1);
      send_request(ACT_CREATE, 64'd2, 32'd1);
      send_request(ACT_CREATE, 64'd3, 32'd1);
      send_request(ACT_REMOVE, '0, '0);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         write_limit(phase_limit[ph]);
         calm = (ph == 6);
         if (ph == 2) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 4)
               key_pool[3'($urandom_range(7))] = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 40)      act = ACT_CREATE;
            else if (pick < 65) act = ACT_VALIDATE;
            else if (pick < 90) act = ACT_REMOVE;
            else                act = ACT_REMOVE_OWNER;
            send_request(act, pick_key(), pick_owner());
         end
         wait_idle();
      end
      calm = 1'b0;

      repeat (10) @(negedge clock);
      if (sessions.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("ERROR: timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> session_slot_table_top.f
rtl/sst_pkg.sv
rtl/sst_ctrl.sv
rtl/sst_datapath.sv
rtl/session_slot_table_top.sv
sim/tb_top.sv
